### design/feq_pkg.sv
// Shared types, codes and match rules for the filtered event ring queue.
package feq_pkg;

	localparam int TYPE_W  = 8;
	localparam int PARAM_W = 32;
	localparam int OWNER_W = 16;

	typedef enum logic [2:0] {
		MODE_ADD     = 3'd0,
		MODE_FETCH   = 3'd1,
		MODE_FIND    = 3'd2,
		MODE_REMOVE  = 3'd3,
		MODE_SCAN    = 3'd4,
		MODE_REWRITE = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_FETCH,
		ST_DONE
	} state_t;

	localparam logic CFG_FREE_TYPE  = 1'b0;
	localparam logic CFG_TIMER_TYPE = 1'b1;

	localparam logic [PARAM_W-1:0] WILD_PARAM = '1;
	localparam logic [OWNER_W-1:0] WILD_OWNER = '1;
	localparam logic [TYPE_W:0]    WILD_TYPE  = '1;

	typedef struct packed {
		logic clear_step;
		logic accept;
		logic fetch_capture;
		logic walk_step;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic empty;
		logic walk_fin;
	} ctl_stat_t;

	// Free slots never match; an all-ones test matches anything; the timer type
	// matches by signed greater-or-equal, every other type by equality.
	function automatic logic param_ok(
		input logic [TYPE_W-1:0]  ty,
		input logic [PARAM_W-1:0] stored,
		input logic [PARAM_W-1:0] test,
		input logic [TYPE_W-1:0]  free_code,
		input logic [TYPE_W-1:0]  timer_code
	);
		logic ok;
		if (ty == free_code) begin
			ok = 1'b0;
		end else if (test == WILD_PARAM) begin
			ok = 1'b1;
		end else if (ty == timer_code) begin
			ok = $signed(stored) >= $signed(test);
		end else begin
			ok = (stored == test);
		end
		return ok;
	endfunction

endpackage

### design/feq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module feq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/feq_ctrl.sv
// Controller state machine: sequences clear, accept, walk, fetch and result hand-off.
module feq_ctrl import feq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [2:0] mode,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (mode)
						MODE_FETCH:  state_d = stat.empty ? ST_DONE : ST_FETCH;
						MODE_FIND,
						MODE_REMOVE,
						MODE_SCAN:   state_d = ST_WALK;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_fin) begin
					state_d = ST_DONE;
				end
			end
			ST_FETCH: begin
				cmd.fetch_capture = 1'b1;
				state_d           = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### design/feq_dpath.sv
// Datapath: slot memories, ring pointers, walk cursor, match logic and result registers.
module feq_dpath import feq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [TYPE_W-1:0]         cfg_data,
	input  logic [2:0]                mode,
	input  logic signed [TYPE_W:0]    ev_type,
	input  logic [TYPE_W-1:0]         type_high,
	input  logic signed [PARAM_W-1:0] ev_param,
	input  logic signed [OWNER_W-1:0] ev_owner,
	input  logic [5:0]                slot_sel,
	input  ctl_cmd_t                  cmd,
	output ctl_stat_t                 stat,
	output logic                      hit,
	output logic [5:0]                hit_slot,
	output logic [TYPE_W-1:0]         hit_type,
	output logic signed [PARAM_W-1:0] hit_param,
	output logic signed [OWNER_W-1:0] hit_owner,
	output logic                      is_empty
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int SW = (AW > 6) ? AW : 6;
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

	function automatic logic [AW-1:0] adv(input logic [AW-1:0] p);
		return (p == LAST) ? '0 : p + AW'(1);
	endfunction

	// configuration
	logic [TYPE_W-1:0] free_q;
	logic [TYPE_W-1:0] timer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= TYPE_W'(0);
			timer_q <= TYPE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FREE_TYPE:  free_q  <= cfg_data;
				CFG_TIMER_TYPE: timer_q <= cfg_data;
				default:        free_q  <= free_q;
			endcase
		end
	end

	// pointers, clear counter, walk control
	logic [AW-1:0] head_q, tail_q, clr_q;
	logic [AW-1:0] cur_q, prev_q;
	logic          pend_q, issue_done_q;

	// latched item
	logic [2:0]         op_mode_q;
	logic [TYPE_W:0]    op_type_q;
	logic [TYPE_W-1:0]  op_high_q;
	logic [PARAM_W-1:0] op_param_q;
	logic [OWNER_W-1:0] op_owner_q;

	// memory ports
	logic               type_we, param_we, owner_we;
	logic [AW-1:0]      type_wa, param_wa, owner_wa, raddr;
	logic [TYPE_W-1:0]  type_wd, rd_type;
	logic [PARAM_W-1:0] param_wd, rd_param;
	logic [OWNER_W-1:0] owner_wd, rd_owner;

	logic [SW:0]   sel_ext;
	logic          sel_ok;
	logic [AW-1:0] sel_addr;
	logic          is_add, is_rewrite, is_fetch, op_remove, in_remove;
	logic          type_eq, pok, find_m, rem_m, scan_m, match, stop, fin, issue;
	logic          empty;

	assign empty    = (head_q == tail_q);
	assign sel_ext  = (SW+1)'(slot_sel);
	assign sel_ok   = sel_ext < (SW+1)'(QUEUE_DEPTH);
	assign sel_addr = sel_ext[AW-1:0];

	assign is_add     = cmd.accept && (mode == MODE_ADD);
	assign is_rewrite = cmd.accept && (mode == MODE_REWRITE) && sel_ok;
	assign is_fetch   = cmd.accept && (mode == MODE_FETCH) && !empty;
	assign in_remove  = (mode == MODE_REMOVE);
	assign op_remove  = (op_mode_q == MODE_REMOVE);

	// slot tests on the word read last cycle
	assign type_eq = !op_type_q[TYPE_W] && (rd_type == op_type_q[TYPE_W-1:0]);
	assign pok     = param_ok(rd_type, rd_param, op_param_q, free_q, timer_q);
	assign find_m  = type_eq && pok;
	assign rem_m   = ((op_owner_q == WILD_OWNER) || (rd_owner == op_owner_q))
		&& ((op_type_q == WILD_TYPE) || type_eq) && pok;
	assign scan_m  = (op_type_q[TYPE_W] || (rd_type >= op_type_q[TYPE_W-1:0]))
		&& (rd_type <= op_high_q);

	always_comb begin
		unique case (op_mode_q)
			MODE_FIND:   match = pend_q && find_m;
			MODE_REMOVE: match = pend_q && rem_m;
			MODE_SCAN:   match = pend_q && scan_m;
			default:     match = 1'b0;
		endcase
	end

	assign stop  = match && !op_remove;
	assign fin   = cmd.walk_step && (stop || issue_done_q);
	assign issue = cmd.walk_step && !stop && !issue_done_q;

	assign stat.clear_last = (clr_q == LAST);
	assign stat.empty      = empty;
	assign stat.walk_fin   = fin;

	// memory write and read selection
	always_comb begin
		type_we  = cmd.clear_step || is_add || (cmd.walk_step && op_remove && match);
		type_wa  = cmd.clear_step ? clr_q : (cmd.accept ? head_q : prev_q);
		type_wd  = cmd.clear_step ? '0 : (cmd.accept ? ev_type[TYPE_W-1:0] : free_q);
		param_we = cmd.clear_step || is_add || is_rewrite;
		param_wa = cmd.clear_step ? clr_q : (is_add ? head_q : sel_addr);
		param_wd = cmd.clear_step ? '0 : ev_param;
		owner_we = cmd.clear_step || is_add;
		owner_wa = cmd.clear_step ? clr_q : head_q;
		owner_wd = cmd.clear_step ? '0 : ev_owner;
		raddr    = cmd.accept ? tail_q : cur_q;
	end

	feq_ram #(.WIDTH(TYPE_W), .DEPTH(QUEUE_DEPTH)) u_type_ram (
		.clk(clk), .we(type_we), .waddr(type_wa), .wdata(type_wd),
		.raddr(raddr), .rdata(rd_type)
	);

	feq_ram #(.WIDTH(PARAM_W), .DEPTH(QUEUE_DEPTH)) u_param_ram (
		.clk(clk), .we(param_we), .waddr(param_wa), .wdata(param_wd),
		.raddr(raddr), .rdata(rd_param)
	);

	feq_ram #(.WIDTH(OWNER_W), .DEPTH(QUEUE_DEPTH)) u_owner_ram (
		.clk(clk), .we(owner_we), .waddr(owner_wa), .wdata(owner_wd),
		.raddr(raddr), .rdata(rd_owner)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			clr_q        <= '0;
			pend_q       <= 1'b0;
			issue_done_q <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= adv(clr_q);
			end
			if (is_add) begin
				head_q <= adv(head_q);
				if (adv(head_q) == tail_q) begin
					tail_q <= adv(tail_q);
				end
			end
			if (is_fetch) begin
				tail_q <= adv(tail_q);
			end
			if (cmd.accept) begin
				pend_q       <= 1'b0;
				issue_done_q <= in_remove ? 1'b0 : empty;
			end else if (issue) begin
				pend_q       <= 1'b1;
				issue_done_q <= op_remove ? (cur_q == LAST) : (adv(cur_q) == head_q);
			end else if (cmd.walk_step) begin
				pend_q <= 1'b0;
			end
		end
	end

	// item, cursor and result registers
	logic               res_hit_q;
	logic [AW-1:0]      res_slot_q;
	logic [TYPE_W-1:0]  res_type_q;
	logic [PARAM_W-1:0] res_param_q;
	logic [OWNER_W-1:0] res_owner_q;
	logic [SW-1:0]      slot_ext;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_mode_q   <= mode;
			op_type_q   <= ev_type;
			op_high_q   <= type_high;
			op_param_q  <= ev_param;
			op_owner_q  <= ev_owner;
			cur_q       <= in_remove ? '0 : tail_q;
			res_hit_q   <= 1'b0;
			res_slot_q  <= is_fetch ? tail_q : '0;
			res_type_q  <= '0;
			res_param_q <= '0;
			res_owner_q <= '0;
		end else begin
			if (issue) begin
				cur_q  <= adv(cur_q);
				prev_q <= cur_q;
			end
			if (cmd.fetch_capture || (cmd.walk_step && stop)) begin
				res_hit_q   <= 1'b1;
				res_type_q  <= rd_type;
				res_param_q <= rd_param;
				res_owner_q <= rd_owner;
			end
			if (cmd.walk_step && stop) begin
				res_slot_q <= prev_q;
			end
		end
	end

	assign slot_ext = SW'(res_slot_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			hit       <= res_hit_q;
			hit_slot  <= slot_ext[5:0];
			hit_type  <= res_type_q;
			hit_param <= res_param_q;
			hit_owner <= res_owner_q;
			is_empty  <= empty;
		end
	end

endmodule

### design/filtered_event_ring_queue_top.sv
// Top level of the filtered event ring queue: controller, datapath and ports.
//
// A ring of QUEUE_DEPTH event slots (type, parameter, owner) driven by one
// operation per input transfer: add at the head (dropping the oldest event when
// the ring wraps onto the tail), fetch from the tail, find the first live
// match, remove every slot that passes a wildcard filter, scan for the first
// type in a range, or rewrite the parameter of one slot. Each input transfer
// produces exactly one output transfer. Slots live in three single-port-read
// memories that one cursor walks one slot per cycle: add, rewrite and unused
// modes go from accept straight to the result register, fetch passes through a
// capture state unless the ring is empty, find and scan walk from the tail up
// to the first hit (at most the live count), and remove walks every slot of
// the ring. After reset the block holds in_stall high while it sweeps zeros
// through the slot memories; configuration writes are taken at any time, also
// during that sweep. A new input transfer is taken while the previous result
// still waits on out_stall.
module filtered_event_ring_queue_top import feq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [TYPE_W-1:0]         cfg_data,
	// input channel
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [2:0]                mode,
	input  logic signed [TYPE_W:0]    ev_type,
	input  logic [TYPE_W-1:0]         type_high,
	input  logic signed [PARAM_W-1:0] ev_param,
	input  logic signed [OWNER_W-1:0] ev_owner,
	input  logic [5:0]                slot_sel,
	// output channel
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit,
	output logic [5:0]                hit_slot,
	output logic [TYPE_W-1:0]         hit_type,
	output logic signed [PARAM_W-1:0] hit_param,
	output logic signed [OWNER_W-1:0] hit_owner,
	output logic                      is_empty
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	// Sequence each operation and hold the finished result until transfer.
	feq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold slots, pointers and match logic; drive the result fields.
	feq_dpath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mode      (mode),
		.ev_type   (ev_type),
		.type_high (type_high),
		.ev_param  (ev_param),
		.ev_owner  (ev_owner),
		.slot_sel  (slot_sel),
		.cmd       (cmd),
		.stat      (stat),
		.hit       (hit),
		.hit_slot  (hit_slot),
		.hit_type  (hit_type),
		.hit_param (hit_param),
		.hit_owner (hit_owner),
		.is_empty  (is_empty)
	);

endmodule

### design/feq_checker.sv
// Port-level checker for the filtered event ring queue, bound to the top level.
module feq_checker #(
	parameter int QUEUE_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [5:0]  hit_slot,
	input logic [7:0]  hit_type,
	input logic [31:0] hit_param,
	input logic [15:0] hit_owner,
	input logic        is_empty
);

	// A stalled result stays valid and keeps its hit flag, slot, parameter and empty flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(hit_slot)
			&& $stable(hit_param) && $stable(is_empty))
		else $error("stalled result changed");

	// A miss carries all-zero slot fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> hit_slot == 6'd0 && hit_type == 8'd0
			&& hit_param == 32'd0 && hit_owner == 16'd0)
		else $error("miss with nonzero slot fields");

	// An accepted item raises in_stall before another item can be taken.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken on back-to-back cycles");

	// A hit names a slot that exists; the check is waived when QUEUE_DEPTH exceeds 64.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> 32'(hit_slot) < QUEUE_DEPTH || QUEUE_DEPTH > 64)
		else $error("hit slot beyond the ring");

endmodule

bind filtered_event_ring_queue_top feq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_feq_checker (.*);
